// ----- rtl/ebb_pkg.sv -----
// Shared types, widths and helpers for the embedding bag backward block.
// No dependencies; used by ebb_ctrl, ebb_datapath and embedding_bag_backward.
`default_nettype none

package ebb_pkg;

    localparam int IN_W      = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 48;
    localparam int ROW_W     = 8;
    localparam int FEAT_W    = 6;
    localparam int CFG_W     = 7;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    localparam logic [CFG_W-1:0] FEAT_LIMIT_RST = 7'd64;
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic KIND_WGRAD = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic update;
        logic load_out;
        logic clear_wr;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic has_result;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic             ovf;
        logic [ACC_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_add(input logic [ACC_W-1:0] acc,
                                     input logic [PROD_W-1:0] add);
        logic [ACC_W:0] s;
        t_sat           r;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){add[PROD_W-1]}}, add};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r.ovf = 1'b1;
            r.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r.ovf = 1'b0;
            r.val = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ebb_ctrl.sv -----
// Controller state machine: clearing pass, accept, fetch, update, emit.
// Depends on ebb_pkg (t_cmd, t_sts).
`default_nettype none

module ebb_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  ebb_pkg::t_sts   i_sts,
    output ebb_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.has_result ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ebb_datapath.sv -----
// Datapath: item registers, multipliers, gradient store memory, dot product,
// output register and feature-limit register. Depends on ebb_pkg.
`default_nettype none

module ebb_datapath #(
    parameter int ROWS    = 256,
    parameter int MAX_DIM = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ebb_pkg::t_cmd                    i_cmd,
    output ebb_pkg::t_sts                    o_sts,
    input  wire                              i_action,
    input  wire  [ebb_pkg::ROW_W-1:0]        i_row,
    input  wire  [ebb_pkg::FEAT_W-1:0]       i_feature,
    input  wire  [ebb_pkg::IN_W-1:0]         i_weight,
    input  wire  [ebb_pkg::IN_W-1:0]         i_value_elem,
    input  wire  [ebb_pkg::IN_W-1:0]         i_dloss_elem,
    input  wire                              i_last_feature,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [ebb_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire                              i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_out_kind,
    output logic [ebb_pkg::ACC_W-1:0]        o_out_grad,
    output logic                             o_out_sat
);

    localparam int DEPTH  = ROWS * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W  = ebb_pkg::ACC_W;

    logic [ACC_W:0] mem [DEPTH];

    logic [ebb_pkg::CFG_W-1:0]       r_feat_limit;
    logic [ADDR_W-1:0]               r_clr_addr;
    logic                            r_action, r_last, r_addr_ok, r_feat_ok;
    logic [ADDR_W-1:0]               r_addr;
    logic signed [ebb_pkg::IN_W-1:0] r_weight, r_value, r_dloss;
    logic signed [ebb_pkg::PROD_W-1:0] r_prod_w, r_prod_v;
    logic [ACC_W:0]                  r_rd;
    logic [ACC_W-1:0]                r_dot;
    logic                            r_dot_sat;
    logic                            r_res_kind, r_res_sat;
    logic [ACC_W-1:0]                r_res_grad;
    logic                            r_out_valid, r_out_kind, r_out_sat;
    logic [ACC_W-1:0]                r_out_grad;

    logic [ADDR_W-1:0] n_addr;
    logic              n_addr_ok, n_feat_ok;
    ebb_pkg::t_sat     w_store_add, w_dot_add;
    logic [ACC_W-1:0]  n_dot;
    logic              n_dot_sat;
    logic              w_wr_en;
    logic [ACC_W:0]    w_wr_data;

    assign o_cfg_ready = 1'b1;

    assign n_addr    = ADDR_W'(32'(i_row) * MAX_DIM + 32'(i_feature));
    assign n_addr_ok = (32'(i_row) < ROWS) && (32'(i_feature) < MAX_DIM);
    assign n_feat_ok = ({1'b0, i_feature} < r_feat_limit) && (32'(i_feature) < MAX_DIM);

    assign w_store_add = ebb_pkg::sat_add(r_rd[ACC_W-1:0], r_prod_w);
    assign w_dot_add   = ebb_pkg::sat_add(r_dot, r_prod_v);
    assign n_dot       = r_feat_ok ? w_dot_add.val : r_dot;
    assign n_dot_sat   = r_dot_sat | (r_feat_ok & w_dot_add.ovf);

    assign w_wr_en   = i_cmd.update && r_addr_ok && (r_action || r_feat_ok);
    assign w_wr_data = (r_action == ebb_pkg::ACT_READ) ? '0 :
                       {r_rd[ACC_W] | w_store_add.ovf, w_store_add.val};

    assign o_sts.clear_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.has_result = r_action | r_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Gradient store with sticky saturation mark in the top bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            mem[r_clr_addr] <= '0;
        end else if (w_wr_en) begin
            mem[r_addr] <= w_wr_data;
        end
        if (i_cmd.fetch) begin
            r_rd <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat_limit <= ebb_pkg::FEAT_LIMIT_RST;
            r_clr_addr   <= '0;
            r_dot        <= '0;
            r_dot_sat    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_feat_limit <= i_cfg_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.update && r_action == ebb_pkg::ACT_ACCUM) begin
                if (r_last) begin
                    r_dot     <= '0;
                    r_dot_sat <= 1'b0;
                end else begin
                    r_dot     <= n_dot;
                    r_dot_sat <= n_dot_sat;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action  <= i_action;
            r_last    <= i_last_feature;
            r_addr    <= n_addr;
            r_addr_ok <= n_addr_ok;
            r_feat_ok <= n_feat_ok;
            r_weight  <= i_weight;
            r_value   <= i_value_elem;
            r_dloss   <= i_dloss_elem;
        end
        if (i_cmd.fetch) begin
            r_prod_w <= r_weight * r_dloss;
            r_prod_v <= r_value * r_dloss;
        end
        if (i_cmd.update) begin
            if (r_action == ebb_pkg::ACT_READ) begin
                r_res_kind <= ebb_pkg::KIND_STORE;
                r_res_grad <= r_addr_ok ? r_rd[ACC_W-1:0] : '0;
                r_res_sat  <= r_addr_ok & r_rd[ACC_W];
            end else begin
                r_res_kind <= ebb_pkg::KIND_WGRAD;
                r_res_grad <= n_dot;
                r_res_sat  <= n_dot_sat;
            end
        end
        if (i_cmd.load_out) begin
            r_out_kind <= r_res_kind;
            r_out_grad <= r_res_grad;
            r_out_sat  <= r_res_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_grad  = r_out_grad;
    assign o_out_sat   = r_out_sat;

endmodule

`default_nettype wire

// ----- rtl/embedding_bag_backward.sv -----
// Top level of the embedding bag backward block.
// Depends on ebb_pkg, ebb_ctrl and ebb_datapath.
//
// Usage:
//   Slave stream: one request per bag entry and feature; tuser is the action
//   (accumulate or read-and-clear), tlast marks the last feature of an entry.
//   Master stream: one result per read request and per accumulate request
//   carrying tlast; tuser is the kind (weight gradient or store entry).
//   Config channel: writes the feature limit; always ready, write only while idle.
// Flow: one request at a time, taken only once the last one has passed the
//   fetch state (store read, multiplies) and the update state (write-back),
//   and the emit state when it gives a result and the output register is free.
// Result: o_m_tvalid rises once the emit state loads the output register.
// Reset: synchronous, active low. After reset a clearing pass zeroes all
//   ROWS*MAX_DIM entries (16384 by default) of the gradient store, with
//   o_s_tready low; config writes are taken during it.
// Stall: a result waits in the output register; a further result waits in
//   the block and no new request is taken until the output frees up.
`default_nettype none

module embedding_bag_backward #(
    parameter int ROWS    = 256,
    parameter int MAX_DIM = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // row[7:0], feature[13:8], weight[29:14], value_elem[45:30],
    // dloss_elem[61:46], zero[63:62]
    input  wire  [ebb_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // action[0]
    input  wire                                i_s_tuser,
    // last_feature
    input  wire                                i_s_tlast,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // gradient[47:0], saturated[48], zero[55:49]
    output logic [ebb_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // kind[0]
    output logic                               o_m_tuser,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [ebb_pkg::CFG_W-1:0]          i_cfg_data
);

    ebb_pkg::t_cmd w_cmd;
    ebb_pkg::t_sts w_sts;
    logic                      w_out_kind, w_out_sat;
    logic [ebb_pkg::ACC_W-1:0] w_out_grad;

    ebb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ebb_datapath #(
        .ROWS    (ROWS),
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_s_tuser),
        .i_row          (i_s_tdata[7:0]),
        .i_feature      (i_s_tdata[13:8]),
        .i_weight       (i_s_tdata[29:14]),
        .i_value_elem   (i_s_tdata[45:30]),
        .i_dloss_elem   (i_s_tdata[61:46]),
        .i_last_feature (i_s_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_out_kind     (w_out_kind),
        .o_out_grad     (w_out_grad),
        .o_out_sat      (w_out_sat)
    );

    assign o_m_tuser = w_out_kind;
    assign o_m_tdata = {{(ebb_pkg::M_TDATA_W - ebb_pkg::ACC_W - 1){1'b0}},
                        w_out_sat, w_out_grad};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while previous one in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("output register overwritten while pending");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_wr |-> !o_s_tready)
        else $error("request accepted during clearing pass");

    a_update_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fetch |=> w_cmd.update)
        else $error("store update did not follow fetch");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/ebb_grad_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for embedding_bag_backward: watches the request, result and config
// channels, predicts each result and compares it field by field.
// Depends on ebb_pkg.

module ebb_grad_checker #(
    parameter int ROWS    = 256,
    parameter int MAX_DIM = 64
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    input  wire                            i_s_tready,
    // row[7:0], feature[13:8], weight[29:14], value_elem[45:30],
    // dloss_elem[61:46], zero[63:62]
    input  wire  [ebb_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // action[0]
    input  wire                            i_s_tuser,
    input  wire                            i_s_tlast,
    input  wire                            i_m_tvalid,
    input  wire                            i_m_tready,
    // gradient[47:0], saturated[48], zero[55:49]
    input  wire  [ebb_pkg::M_TDATA_W-1:0]  i_m_tdata,
    // kind[0]
    input  wire                            i_m_tuser,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire  [ebb_pkg::CFG_W-1:0]      i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    localparam longint ACC_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_BOTTOM = -ACC_TOP - 1;

    typedef struct packed {
        logic                      kind;
        logic                      sat;
        logic [ebb_pkg::ACC_W-1:0] grad;
    } t_grad_result;

    longint       grad_mem [ROWS*MAX_DIM];
    bit           sat_mem  [ROWS*MAX_DIM];
    longint       dot_acc    = 0;
    bit           dot_sat    = 1'b0;
    int           feat_limit = int'(ebb_pkg::FEAT_LIMIT_RST);
    int           errors     = 0;
    t_grad_result pending_grads [$];

    function automatic longint clamp48(input longint s);
        if (s > ACC_TOP) begin
            return ACC_TOP;
        end else if (s < ACC_BOTTOM) begin
            return ACC_BOTTOM;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    task automatic update_gradients(input logic [ebb_pkg::S_TDATA_W-1:0] data,
                                    input logic act, input logic last);
        int           row;
        int           feat;
        int           slot;
        longint       wgt;
        longint       val;
        longint       dls;
        longint       sum;
        longint       stored;
        t_grad_result res;
        row  = int'(data[7:0]);
        feat = int'(data[13:8]);
        wgt  = longint'($signed(data[29:14]));
        val  = longint'($signed(data[45:30]));
        dls  = longint'($signed(data[61:46]));
        slot = row * MAX_DIM + feat;
        if (act == ebb_pkg::ACT_READ) begin
            res.kind = ebb_pkg::KIND_STORE;
            res.grad = '0;
            res.sat  = 1'b0;
            if (row < ROWS && feat < MAX_DIM) begin
                stored         = grad_mem[slot];
                res.grad       = stored[ebb_pkg::ACC_W-1:0];
                res.sat        = sat_mem[slot];
                grad_mem[slot] = 0;
                sat_mem[slot]  = 1'b0;
            end
            pending_grads.push_back(res);
        end else begin
            if (feat < feat_limit && feat < MAX_DIM) begin
                sum     = dot_acc + val * dls;
                dot_acc = clamp48(sum);
                if (dot_acc != sum) dot_sat = 1'b1;
                if (row < ROWS) begin
                    sum            = grad_mem[slot] + wgt * dls;
                    grad_mem[slot] = clamp48(sum);
                    if (grad_mem[slot] != sum) sat_mem[slot] = 1'b1;
                end
            end
            if (last) begin
                res.kind = ebb_pkg::KIND_WGRAD;
                res.grad = dot_acc[ebb_pkg::ACC_W-1:0];
                res.sat  = dot_sat;
                pending_grads.push_back(res);
                dot_acc = 0;
                dot_sat = 1'b0;
            end
        end
    endtask

    task automatic check_result();
        t_grad_result want;
        if (pending_grads.size() == 0) begin
            report_mismatch("result with none pending", '0, 64'({i_m_tuser, i_m_tdata}));
        end else begin
            want = pending_grads.pop_front();
            if (i_m_tuser != want.kind)
                report_mismatch("kind", 64'(want.kind), 64'(i_m_tuser));
            if (i_m_tdata[ebb_pkg::ACC_W-1:0] != want.grad)
                report_mismatch("gradient", 64'(want.grad),
                                64'(i_m_tdata[ebb_pkg::ACC_W-1:0]));
            if (i_m_tdata[ebb_pkg::ACC_W] != want.sat)
                report_mismatch("saturated", 64'(want.sat), 64'(i_m_tdata[ebb_pkg::ACC_W]));
        end
    endtask

    // request before result: a same-edge result always belongs to an older request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) feat_limit = int'(i_cfg_data);
            if (i_s_tvalid && i_s_tready) update_gradients(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_result();
        end
        o_pending    <= pending_grads.size();
        o_fail_count <= errors;
    end

endmodule

// ----- tb/sv/embedding_bag_backward_test.sv -----
`timescale 1ns / 100ps
// Testbench top for embedding_bag_backward: drives requests, config writes and
// result backpressure, and prints the verdict from ebb_grad_checker.
// Depends on ebb_pkg, the block RTL and ebb_grad_checker.

module embedding_bag_backward_test;

    localparam int          WATCHDOG_LIMIT  = 100000;
    localparam int          ITEMS_PER_PHASE = 425;
    localparam int          SAT_RUN         = 64;
    localparam logic [15:0] Q_MIN           = 16'h8000;
    localparam logic [15:0] Q_MAX           = 16'h7FFF;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [ebb_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          s_tuser   = ebb_pkg::ACT_ACCUM;
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [ebb_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ebb_pkg::CFG_W-1:0]     cfg_data  = '0;

    int         outstanding;
    int         mismatches;
    int         send_idle_pct  = 0;
    int         sink_stall_pct = 0;
    int         quiet_cycles   = 0;
    int         sent           = 0;
    int         dim_now        = 64;
    logic [7:0] hot_rows [8];

    embedding_bag_backward dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ebb_grad_checker grad_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (outstanding),
        .o_fail_count (mismatches)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // the clearing pass after reset accepts no requests
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] rand_q88();
        case ($urandom_range(9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_row();
        if ($urandom_range(3) != 0) begin
            return hot_rows[$urandom_range(7)];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_req(input logic act, input logic [7:0] row, input logic [5:0] feat,
                            input logic [15:0] wgt, input logic [15:0] val,
                            input logic [15:0] dls, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tlast  <= last;
        s_tdata  <= {2'b00, dls, val, wgt, feat, row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // requests without a result may still be in flight after the last result
    task automatic wait_idle();
        drain_results();
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [ebb_pkg::CFG_W-1:0] dim);
        cfg_valid <= 1'b1;
        cfg_data  <= dim;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        dim_now = int'(dim);
    endtask

    task automatic send_bag_entry();
        logic [7:0]  row;
        logic [15:0] wgt;
        int          n;
        row = pick_row();
        wgt = rand_q88();
        if ($urandom_range(15) == 0) begin
            n = dim_now;
        end else begin
            n = $urandom_range((dim_now < 6) ? dim_now : 6, 1);
        end
        for (int f = 0; f < n; f++) begin
            send_req(ebb_pkg::ACT_ACCUM, row, 6'(f), wgt, rand_q88(), rand_q88(),
                     f == n - 1);
        end
    endtask

    task automatic send_read();
        logic [5:0] feat;
        if ($urandom_range(3) != 0) begin
            feat = 6'($urandom_range(dim_now - 1));
        end else begin
            feat = 6'($urandom_range(63));
        end
        send_req(ebb_pkg::ACT_READ, pick_row(), feat, rand_q88(), rand_q88(), rand_q88(),
                 1'($urandom_range(1)));
    endtask

    task automatic send_noise();
        send_req(1'($urandom_range(1)), 8'($urandom_range(255)), 6'($urandom_range(63)),
                 rand_q88(), rand_q88(), rand_q88(), 1'($urandom_range(1)));
    endtask

    initial begin
        int roll;
        int target;
        bit paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        cfg_write(7'd64);

        // full-scale products, read in the middle of an entry, reads with tlast
        send_req(ebb_pkg::ACT_ACCUM, 8'd0, 6'd0, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        send_req(ebb_pkg::ACT_ACCUM, 8'd0, 6'd1, Q_MIN, Q_MAX, Q_MIN, 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd0, 6'd0, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_ACCUM, 8'd255, 6'd63, Q_MAX, Q_MAX, Q_MAX, 1'b1);
        send_req(ebb_pkg::ACT_ACCUM, 8'd255, 6'd63, Q_MIN, Q_MIN, Q_MAX, 1'b1);
        send_req(ebb_pkg::ACT_ACCUM, 8'd3, 6'd2, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_req(ebb_pkg::ACT_ACCUM, 8'd10, 6'd20, Q_MAX, 16'h0001, Q_MIN, 1'b1);
        send_req(ebb_pkg::ACT_ACCUM, 8'd7, 6'd4, 16'h0100, 16'hFFFF, 16'h0001, 1'b0);
        send_req(ebb_pkg::ACT_ACCUM, 8'd7, 6'd4, 16'hFF00, 16'h0080, 16'h0200, 1'b1);
        send_req(ebb_pkg::ACT_READ, 8'd0, 6'd1, rand_q88(), rand_q88(), rand_q88(), 1'b1);
        send_req(ebb_pkg::ACT_READ, 8'd255, 6'd63, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd255, 6'd63, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd128, 6'd32, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd7, 6'd4, rand_q88(), rand_q88(), rand_q88(), 1'b1);

        // one feature in use: ignored features still close an entry
        wait_idle();
        cfg_write(7'd1);
        send_req(ebb_pkg::ACT_ACCUM, 8'd9, 6'd0, Q_MAX, Q_MIN, Q_MAX, 1'b0);
        send_req(ebb_pkg::ACT_ACCUM, 8'd9, 6'd1, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        send_req(ebb_pkg::ACT_ACCUM, 8'd9, 6'd63, Q_MIN, Q_MIN, Q_MIN, 1'b1);
        send_req(ebb_pkg::ACT_ACCUM, 8'd9, 6'd5, Q_MIN, Q_MAX, Q_MIN, 1'b1);
        send_req(ebb_pkg::ACT_READ, 8'd9, 6'd0, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd9, 6'd1, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd10, 6'd20, rand_q88(), rand_q88(), rand_q88(), 1'b0);

        // run on one entry: dot product grows high, store entry grows low
        wait_idle();
        cfg_write(7'd64);
        for (int i = 0; i < SAT_RUN; i++) begin
            send_req(ebb_pkg::ACT_ACCUM, 8'd200, 6'd7, Q_MAX, Q_MIN, Q_MIN, i == SAT_RUN - 1);
        end
        send_req(ebb_pkg::ACT_READ, 8'd200, 6'd7, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_READ, 8'd200, 6'd7, rand_q88(), rand_q88(), rand_q88(), 1'b0);
        send_req(ebb_pkg::ACT_ACCUM, 8'd200, 6'd7, 16'h0001, 16'h0001, 16'h0001, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                    cfg_write(7'($urandom_range(63, 2)));
                end
                1: begin
                    send_idle_pct  = 59;
                    sink_stall_pct = 0;
                    cfg_write(7'd64);
                end
                2: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 59;
                    cfg_write(7'd1);
                end
                default: begin
                    send_idle_pct  = 9;
                    sink_stall_pct = 9;
                    cfg_write(7'($urandom_range(63, 2)));
                end
            endcase
            for (int k = 0; k < 8; k++) begin
                hot_rows[k] = 8'($urandom_range(255));
            end
            target = sent + ITEMS_PER_PHASE;
            while (sent < target) begin
                if (ph == 1 && !paused && sent >= target - ITEMS_PER_PHASE / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 70) begin
                    send_bag_entry();
                end else if (roll < 85) begin
                    send_read();
                end else begin
                    send_noise();
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ebb_pkg.sv
rtl/ebb_ctrl.sv
rtl/ebb_datapath.sv
rtl/embedding_bag_backward.sv
tb/sv/ebb_grad_checker.sv
tb/sv/embedding_bag_backward_test.sv
